FILE: rtl/nmo3_pkg.sv
// Package: shared types and constants for the nth-multiple search block.
`timescale 1ns / 1ps
package nmo3_pkg;
    localparam int IN_W  = 30;
    localparam int OUT_W = 31;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_GCD   = 9'b000000010,
        S_GWAIT = 9'b000000100,
        S_QDIV  = 9'b000001000,
        S_QWAIT = 9'b000010000,
        S_MID   = 9'b000100000,
        S_CDIV  = 9'b001000000,
        S_CWAIT = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctrl;
endpackage

FILE: rtl/nmo3_div.sv
// Shared bit-serial restoring divider: quotient and remainder, one bit per cycle.
`timescale 1ns / 1ps
module nmo3_div import nmo3_pkg::*; #(
    parameter int W = 50
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_div_ctrl     i_ctrl,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    output logic          o_busy,
    output logic          o_done,
    output logic [W-1:0]  o_quo,
    output logic [W-1:0]  o_rem
);
    localparam int CW = $clog2(W + 1);
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_den;
    logic [W:0]    n_shift;
    logic [W:0]    n_diff;

    assign n_shift = {r_rem, r_quo[W-1]};
    assign n_diff  = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!n_diff[W]) begin
                    r_rem <= n_diff[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

FILE: rtl/nth_multiple_of_any_of_three.sv
// Top level: nth multiple of any of three periods, lcm setup and binary search.
//
// Usage: a request on the slave stream carries query_n and three periods
// (tdata, from bit 0: query_n, period_a, period_b, period_c; 120 bits).
// The result leaves on the master stream (tdata bit 0 up: nth_value).
// One request at a time: s_axis_tready is high only while idle.
// Operation: the four lcm steps run Euclid's gcd then a quotient on one
// shared bit-serial divider (W = SEARCH_BITS+19 bits); the search then
// runs at most SEARCH_BITS steps of seven divisions each.
// The result is held in an output register until taken; while the
// receiver stalls, the block holds it and accepts no new request.
// Reset clears the sequencer and output valid; the block is idle after.
`timescale 1ns / 1ps
module nth_multiple_of_any_of_three import nmo3_pkg::*; #(
    parameter int SEARCH_BITS = 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [119:0]  s_axis_tdata,   // query_n, period_a, period_b, period_c
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [31:0]   m_axis_tdata    // nth_value, zero pad
);
    localparam int SB = SEARCH_BITS;
    localparam int W  = SB + 19;
    localparam logic [W-1:0] CAP = W'(1) << SB;

    t_state        r_state;
    logic [W-1:0]  r_x, r_y;
    logic [W-1:0]  r_lcm [4];
    logic [W-1:0]  r_per [3];
    logic [1:0]    r_li;
    logic [2:0]    r_ti;
    logic [W-1:0]  r_lo, r_hi, r_mid, r_cnt;
    logic [IN_W-1:0] r_n;
    logic [OUT_W-1:0] r_res;
    logic          r_ov;
    t_div_ctrl     n_ctrl;
    logic [W-1:0]  n_num, n_den;
    logic          w_busy, w_done;
    logic [W-1:0]  w_quo, w_rem;
    logic [W-1:0]  w_pa, w_pb, w_pc;
    logic [W-1:0]  w_oa, w_ob;
    logic [W-1:0]  w_term;
    logic [2*SB-1:0] w_prod;

    nmo3_div #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(n_ctrl),
        .i_num(n_num), .i_den(n_den), .o_busy(w_busy), .o_done(w_done),
        .o_quo(w_quo), .o_rem(w_rem)
    );

    function automatic logic [W-1:0] eff(input logic [IN_W-1:0] p);
        eff = (p == '0) ? CAP : W'(p);
    endfunction

    assign w_pa = eff(s_axis_tdata[59:30]);
    assign w_pb = eff(s_axis_tdata[89:60]);
    assign w_pc = eff(s_axis_tdata[119:90]);

    always_comb begin
        case (r_li)
            2'd0:    begin w_oa = r_per[0]; w_ob = r_per[1]; end
            2'd1:    begin w_oa = r_per[0]; w_ob = r_per[2]; end
            2'd2:    begin w_oa = r_per[1]; w_ob = r_per[2]; end
            default: begin w_oa = r_lcm[0]; w_ob = r_per[2]; end
        endcase
    end

    always_comb begin
        case (r_ti)
            3'd0:    w_term = r_per[0];
            3'd1:    w_term = r_per[1];
            3'd2:    w_term = r_per[2];
            3'd3:    w_term = r_lcm[3];
            3'd4:    w_term = r_lcm[0];
            3'd5:    w_term = r_lcm[1];
            default: w_term = r_lcm[2];
        endcase
    end

    assign w_prod = w_quo[SB-1:0] * w_ob[SB-1:0];

    always_comb begin
        n_ctrl.start = 1'b0;
        n_num = r_x;
        n_den = r_y;
        case (r_state)
            S_GCD: begin
                if (r_y != '0) n_ctrl.start = 1'b1;
            end
            S_QDIV: n_ctrl.start = 1'b1;
            S_CDIV: begin
                n_ctrl.start = 1'b1;
                n_num = r_mid;
                n_den = w_term;
            end
            default: n_ctrl.start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_n      <= s_axis_tdata[29:0];
                        r_per[0] <= w_pa;
                        r_per[1] <= w_pb;
                        r_per[2] <= w_pc;
                        r_li     <= 2'd0;
                        r_state  <= S_GCD;
                        r_x      <= w_pa;
                        r_y      <= w_pb;
                    end
                end
                S_GCD: begin
                    if (w_oa >= CAP || w_ob >= CAP) begin
                        r_lcm[r_li] <= CAP;
                        if (r_li == 2'd3) begin
                            r_lo <= W'(1); r_hi <= CAP - W'(1);
                            r_state <= S_MID;
                        end else begin
                            r_li <= r_li + 2'd1;
                        end
                        r_x <= (r_li == 2'd0) ? r_per[0] :
                               (r_li == 2'd1) ? r_per[1] : CAP;
                        r_y <= r_per[2];
                    end else if (r_y == '0) begin
                        r_y <= r_x;
                        r_x <= w_oa;
                        r_state <= S_QDIV;
                    end else begin
                        r_state <= S_GWAIT;
                    end
                end
                S_GWAIT: begin
                    if (w_done) begin
                        r_x <= r_y;
                        r_y <= w_rem;
                        r_state <= S_GCD;
                    end
                end
                S_QDIV: r_state <= S_QWAIT;
                S_QWAIT: begin
                    if (w_done) begin
                        if (w_prod >= (2*SB)'(CAP)) r_lcm[r_li] <= CAP;
                        else r_lcm[r_li] <= W'(w_prod);
                        r_state <= S_GCD;
                        if (r_li == 2'd3) begin
                            r_lo <= W'(1); r_hi <= CAP - W'(1);
                            r_state <= S_MID;
                        end else begin
                            r_li <= r_li + 2'd1;
                            r_x <= (r_li == 2'd2) ? r_lcm[0] :
                                   (r_li == 2'd0) ? r_per[0] : r_per[1];
                            r_y <= r_per[2];
                        end
                        if (r_li == 2'd2 && r_lcm[0] >= CAP) r_x <= CAP;
                    end
                end
                S_MID: begin
                    if (r_lo < r_hi) begin
                        r_mid <= r_lo + ((r_hi - r_lo) >> 1);
                        r_cnt <= '0;
                        r_ti <= 3'd0;
                        r_state <= S_CDIV;
                    end else begin
                        r_res <= r_lo[OUT_W-1:0];
                        r_ov <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_CDIV: r_state <= S_CWAIT;
                S_CWAIT: begin
                    if (w_done) begin
                        if (r_ti < 3'd4) r_cnt <= r_cnt + w_quo;
                        else r_cnt <= r_cnt - w_quo;
                        if (r_ti == 3'd6) begin
                            r_state <= S_MID;
                            if ((r_cnt - w_quo) >= W'(r_n)) r_hi <= r_mid;
                            else r_lo <= r_mid + W'(1);
                        end else begin
                            r_ti <= r_ti + 3'd1;
                            r_state <= S_CDIV;
                        end
                    end
                end
                S_DONE: begin
                    if (m_axis_tready) begin
                        r_ov <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_res};

`ifndef SYNTH
    a_ov_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> r_state == S_DONE) else $error("valid outside done");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !s_axis_tready) else $error("ready while dividing");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MID) |-> r_lo <= r_hi) else $error("search bounds crossed");
`endif
endmodule
